// ===== src/rhsm_pkg.sv =====
`default_nettype none

package rhsm_pkg;

   localparam int BYTE_W              = 8;
   localparam int DIGIT_W             = 2;
   localparam int LEN_W               = 5;
   localparam int POS_W               = 32;
   localparam int PAT_BYTES           = 16;
   localparam int CSR_ADDR_W          = 5;
   localparam int CSR_DATA_W          = 64;
   localparam int MAX_PATTERN_DEFAULT = 16;

   typedef enum logic [1:0] {
      REG_PATTERN_LENGTH = 2'd0,
      REG_PATTERN_LOW    = 2'd1,
      REG_PATTERN_HIGH   = 2'd2
   } csr_index_type;

   // window hit found on an accepted byte
   typedef struct packed {
      logic             hit;
      logic [POS_W-1:0] start;
   } hit_type;

   // byte mod 3: base-4 digits sum to the same residue
   function automatic logic [DIGIT_W-1:0] mod3_byte(input logic [BYTE_W-1:0] b);
      logic [3:0] s;
      logic [DIGIT_W-1:0] r;
      s = {2'b00, b[1:0]} + {2'b00, b[3:2]} + {2'b00, b[5:4]} + {2'b00, b[7:6]};
      case (s)
         4'd0, 4'd3, 4'd6, 4'd9, 4'd12: r = 2'd0;
         4'd1, 4'd4, 4'd7, 4'd10:       r = 2'd1;
         4'd2, 4'd5, 4'd8, 4'd11:       r = 2'd2;
         default:                       r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [BYTE_W-1:0] pattern_byte(input logic [CSR_DATA_W-1:0] low,
                                                     input logic [CSR_DATA_W-1:0] high,
                                                     input logic [3:0]            idx);
      logic [CSR_DATA_W-1:0] word;
      word = idx[3] ? high : low;
      return word[idx[2:0]*BYTE_W +: BYTE_W];
   endfunction

endpackage

`default_nettype wire

// ===== src/rolling_hash_substring_matcher_core.sv =====
// Substring matcher over a byte stream, one text byte per transfer with a
// line-start flag. Each byte updates a base-3 digit window (byte mod 3 per
// digit, oldest byte lowest) held in a shift line, and is written into a
// small ring RAM addressed by its stream position. When a full window of the
// current line carries the pattern's digits, the matching bytes are read back
// from the ring one per cycle unless the result side stalls, and compared with
// the pattern; one result (1-based position, last_of_run flag) is sent per
// compared byte up to and including the first mismatch. Without a hit the
// block takes one byte every cycle. A hit holds off input while its run is
// read back via the ring's single read port, longer if the result side stalls.
// Pattern registers sit at byte addresses 0, 8 and 16 of the 64-bit register
// port; the user must write them only while no byte is in flight; the block does not enforce it.
`default_nettype none

module rolling_hash_substring_matcher_core
   import rhsm_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [BYTE_W-1:0]     req_text_byte,
   input  wire logic                  req_line_start,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [POS_W-1:0]           rsp_position,
   output logic                       rsp_last_of_run,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   localparam int RING_BITS  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int RING_DEPTH = 1 << RING_BITS;

   logic [LEN_W-1:0]      pattern_length_ff;
   logic [CSR_DATA_W-1:0] pattern_low_ff;
   logic [CSR_DATA_W-1:0] pattern_high_ff;
   logic [LEN_W-1:0]      len;
   logic                  csr_write;
   csr_index_type         csr_index;

   logic                  wr_en;
   logic [RING_BITS-1:0]  wr_addr;
   logic [BYTE_W-1:0]     wr_data;
   logic                  rd_en;
   logic [RING_BITS-1:0]  rd_addr;
   logic [BYTE_W-1:0]     rd_data;
   hit_type               hit;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[4:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= LEN_W'(1);
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_PATTERN_LENGTH: pattern_length_ff <= csr_pwdata[LEN_W-1:0];
            REG_PATTERN_LOW:    pattern_low_ff    <= csr_pwdata;
            REG_PATTERN_HIGH:   pattern_high_ff   <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_PATTERN_LENGTH: csr_prdata = CSR_DATA_W'(pattern_length_ff);
         REG_PATTERN_LOW:    csr_prdata = pattern_low_ff;
         REG_PATTERN_HIGH:   csr_prdata = pattern_high_ff;
         default:            csr_prdata = '0;
      endcase
   end

   // zero acts as one, oversize as capacity
   always_comb begin
      priority if (pattern_length_ff == '0) begin
         len = LEN_W'(1);
      end else if (pattern_length_ff > LEN_W'(MAX_PATTERN)) begin
         len = LEN_W'(MAX_PATTERN);
      end else begin
         len = pattern_length_ff;
      end
   end

   rhsm_window #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_window (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_text_byte  (req_text_byte),
      .req_line_start (req_line_start),
      .len            (len),
      .pattern_low    (pattern_low_ff),
      .pattern_high   (pattern_high_ff),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .hit            (hit)
   );

   rhsm_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rhsm_emit #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_emit (
      .clock           (clock),
      .reset           (reset),
      .hit             (hit),
      .len             (len),
      .pattern_low     (pattern_low_ff),
      .pattern_high    (pattern_high_ff),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data),
      .req_stall       (req_stall),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_position    (rsp_position),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

// ===== src/rhsm_ram.sv =====
`default_nettype none

module rhsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]             wr_data,
   input  wire logic                         rd_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic      [WIDTH-1:0]             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/rhsm_window.sv =====
`default_nettype none

module rhsm_window
   import rhsm_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire logic [BYTE_W-1:0]     req_text_byte,
   input  wire logic                  req_line_start,
   input  wire logic [LEN_W-1:0]      len,
   input  wire logic [CSR_DATA_W-1:0] pattern_low,
   input  wire logic [CSR_DATA_W-1:0] pattern_high,
   output logic                       wr_en,
   output logic [(MAX_PATTERN > 1 ? $clog2(MAX_PATTERN) : 1)-1:0] wr_addr,
   output logic [BYTE_W-1:0]          wr_data,
   output hit_type                    hit
);

   localparam int RING_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [POS_W-1:0]   count_ff, count_in;
   logic [LEN_W-1:0]   line_fill_ff, line_fill_in;
   logic [DIGIT_W-1:0] digits_ff [MAX_PATTERN];
   logic [DIGIT_W-1:0] digits_in [MAX_PATTERN];
   logic [DIGIT_W-1:0] pat_digit [PAT_BYTES];
   logic [LEN_W-1:0]   fill_base;
   logic [LEN_W-1:0]   fill_clamp;
   logic [LEN_W-1:0]   mirror;
   logic               accept;
   logic               digits_match;

   assign accept   = req_valid && !req_stall;
   assign count_in = count_ff + POS_W'(1);

   always_comb begin
      fill_base    = req_line_start ? '0 : line_fill_ff;
      fill_clamp   = (fill_base > len) ? len : fill_base;
      line_fill_in = (fill_clamp < len) ? fill_clamp + LEN_W'(1) : fill_clamp;
   end

   always_comb begin
      for (int k = 0; k < PAT_BYTES; k++) begin
         pat_digit[k] = mod3_byte(pattern_byte(pattern_low, pattern_high, 4'(k)));
      end
   end

   // newest digit at offset zero, oldest in use at len - 1
   always_comb begin
      digits_in[0] = mod3_byte(req_text_byte);
      for (int j = 1; j < MAX_PATTERN; j++) begin
         digits_in[j] = digits_ff[j-1];
      end
   end

   always_comb begin
      digits_match = 1'b1;
      mirror       = '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         mirror = len - LEN_W'(j) - LEN_W'(1);
         if (LEN_W'(j) < len && digits_in[j] != pat_digit[mirror[3:0]]) begin
            digits_match = 1'b0;
         end
      end
   end

   assign hit.hit   = accept && (line_fill_in == len) && digits_match;
   assign hit.start = count_in - POS_W'(len) + POS_W'(1);

   assign wr_en   = accept;
   assign wr_addr = count_in[RING_BITS-1:0];
   assign wr_data = req_text_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         line_fill_ff <= '0;
      end else if (accept) begin
         count_ff     <= count_in;
         line_fill_ff <= line_fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int j = 0; j < MAX_PATTERN; j++) begin
            digits_ff[j] <= digits_in[j];
         end
      end
   end

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      line_fill_ff <= LEN_W'(MAX_PATTERN))
      else $error("line fill beyond pattern capacity");

   a_hit_needs_full_line: assert property (@(posedge clock) disable iff (reset)
      hit.hit |-> (req_line_start ? (len == LEN_W'(1)) : (line_fill_ff + LEN_W'(1) >= len)))
      else $error("hit on a window shorter than the pattern");

endmodule

`default_nettype wire

// ===== src/rhsm_emit.sv =====
`default_nettype none

module rhsm_emit
   import rhsm_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire hit_type               hit,
   input  wire logic [LEN_W-1:0]      len,
   input  wire logic [CSR_DATA_W-1:0] pattern_low,
   input  wire logic [CSR_DATA_W-1:0] pattern_high,
   output logic                       rd_en,
   output logic [(MAX_PATTERN > 1 ? $clog2(MAX_PATTERN) : 1)-1:0] rd_addr,
   input  wire logic [BYTE_W-1:0]     rd_data,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [POS_W-1:0]           rsp_position,
   output logic                       rsp_last_of_run
);

   localparam int RING_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic             issuing_ff;
   logic [POS_W-1:0] iss_pos_ff;
   logic [LEN_W-1:0] iss_k_ff;
   logic             dat_valid_ff;
   logic [POS_W-1:0] dat_pos_ff;
   logic [LEN_W-1:0] dat_k_ff;
   logic             out_valid_ff;
   logic [POS_W-1:0] out_pos_ff;
   logic             out_last_ff;

   logic out_free;
   logic dat_last;
   logic move;
   logic issue;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign dat_last = (rd_data != pattern_byte(pattern_low, pattern_high, dat_k_ff[3:0]))
                     || (dat_k_ff == len - LEN_W'(1));
   assign move     = dat_valid_ff && out_free;
   assign issue    = issuing_ff && (!dat_valid_ff || (move && !dat_last));

   assign rd_en   = issue;
   assign rd_addr = iss_pos_ff[RING_BITS-1:0];

   // ring slots stay untouched while a run is read back
   assign req_stall = issuing_ff || dat_valid_ff;

   assign rsp_valid       = out_valid_ff;
   assign rsp_position    = out_pos_ff;
   assign rsp_last_of_run = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff   <= 1'b0;
         dat_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         priority if (hit.hit) begin
            issuing_ff <= 1'b1;
            iss_pos_ff <= hit.start;
            iss_k_ff   <= '0;
         end else if (issue) begin
            issuing_ff <= (iss_k_ff != len - LEN_W'(1));
            iss_pos_ff <= iss_pos_ff + POS_W'(1);
            iss_k_ff   <= iss_k_ff + LEN_W'(1);
         end else if (move && dat_last) begin
            issuing_ff <= 1'b0;
         end else begin
            issuing_ff <= issuing_ff;
         end

         priority if (issue) begin
            dat_valid_ff <= 1'b1;
            dat_pos_ff   <= iss_pos_ff;
            dat_k_ff     <= iss_k_ff;
         end else if (move) begin
            dat_valid_ff <= 1'b0;
         end else begin
            dat_valid_ff <= dat_valid_ff;
         end

         priority if (move) begin
            out_valid_ff <= 1'b1;
            out_pos_ff   <= dat_pos_ff;
            out_last_ff  <= dat_last;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= out_valid_ff;
         end
      end
   end

   a_hit_when_idle: assert property (@(posedge clock) disable iff (reset)
      hit.hit |-> (!issuing_ff && !dat_valid_ff))
      else $error("hit while a comparison run is in progress");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (move && dat_last) |=> !issuing_ff)
      else $error("reads continue past the end of a run");

   a_index_in_pattern: assert property (@(posedge clock) disable iff (reset)
      dat_valid_ff |-> (dat_k_ff < len))
      else $error("compared byte index beyond pattern length");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rhsm_pkg::*;

   localparam int HOLD_CYCLES   = 400;
   localparam int IDLE_LIMIT    = 5000;
   localparam int TARGET_ITEMS  = 380;
   localparam int PHASE_ITEMS   = 40;
   localparam int SETTLE_CYCLES = 12;

   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic             last;
   } compared_byte_type;

   typedef enum logic {ROW_CSR, ROW_TEXT} row_kind_type;

   typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_SQUARE, STALL_SPARSE} stall_mode_type;

   typedef struct packed {
      row_kind_type          kind;
      csr_index_type         reg_idx;
      logic [CSR_DATA_W-1:0] value;
      logic [BYTE_W-1:0]     text;
      logic                  line_start;
      logic                  typed;
      logic                  hit;
      logic [POS_W-1:0]      pos;
      logic                  last;
   } script_row_type;

   // typed rows carry at most one result, the rest go through the predictor
   localparam script_row_type SCRIPT [31] = '{
      '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'h00, 1'b0, 1'b1, 1'b1, 32'd1, 1'b1},
      '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b0, 1'b1, 1'b1, 32'd2, 1'b1},
      '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'h01, 1'b1, 1'b1, 1'b0, 32'd0, 1'b0},
      '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'h80, 1'b0, 1'b1, 1'b0, 32'd0, 1'b0},
      '{ROW_CSR, REG_PATTERN_LENGTH, 64'd0, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_CSR, REG_PATTERN_LOW, 64'h0000_0000_0000_00AA, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0,
        1'b0},
      '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'hAA, 1'b0, 1'b1, 1'b1, 32'd5, 1'b1},
      '{ROW_CSR, REG_PATTERN_LENGTH, 64'd31, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_CSR, REG_PATTERN_LOW, 64'h8877_6655_4433_2211, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0,
        1'b0},
      '{ROW_CSR, REG_PATTERN_HIGH, 64'hFF00_EEDD_CCBB_AA99, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0,
        1'b0},
      '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'h11, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'h22, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'h33, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'h44, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'h55, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'h66, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'h77, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'h88, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'h99, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'hAA, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'hBB, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'hCC, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'hDD, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'hEE, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_CSR, REG_PATTERN_LENGTH, 64'd2, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'h22, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'h11, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'h25, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
      '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'h22, 1'b1, 1'b1, 1'b0, 32'd0, 1'b0}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_text_byte;
   logic                  req_line_start;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [POS_W-1:0]      rsp_position;
   logic                  rsp_last_of_run;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // predictor state
   logic [BYTE_W-1:0]     held [PAT_BYTES];
   logic [LEN_W-1:0]      held_count;
   logic [POS_W-1:0]      stream_pos;
   logic [LEN_W-1:0]      len_reg;
   logic [CSR_DATA_W-1:0] pat_lo_reg;
   logic [CSR_DATA_W-1:0] pat_hi_reg;

   compared_byte_type expected_runs [$];
   compared_byte_type scan_run [$];

   int   fail_count   = 0;
   int   items_sent   = 0;
   int   burst_left   = 0;
   logic gaps_on      = 1'b1;
   logic hold_request = 1'b0;

   rolling_hash_substring_matcher_core u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned active_len();
      int unsigned n;
      n = 32'(len_reg);
      if (n < 1) n = 1;
      if (n > MAX_PATTERN_DEFAULT) n = MAX_PATTERN_DEFAULT;
      return n;
   endfunction

   function automatic logic [BYTE_W-1:0] pat_at(input int unsigned k);
      logic [CSR_DATA_W-1:0] word;
      word = (k < 8) ? pat_lo_reg : pat_hi_reg;
      return word[(k % 8) * BYTE_W +: BYTE_W];
   endfunction

   // advance the predictor by one text byte, leaving its comparison run in scan_run
   function automatic void predict_scan(input logic [BYTE_W-1:0] b, input logic ls);
      int unsigned       n, k, wh, ph, p3;
      logic [POS_W-1:0]  first;
      logic              differs;
      compared_byte_type item;
      n = active_len();
      scan_run.delete();
      stream_pos = stream_pos + 1;
      if (ls) begin
         foreach (held[i]) held[i] = '0;
         held_count = '0;
      end
      if (held_count > n) held_count = LEN_W'(n);
      for (k = PAT_BYTES - 1; k > 0; k--) held[k] = held[k-1];
      held[0] = b;
      if (held_count < n) held_count = held_count + LEN_W'(1);
      wh = 0;
      ph = 0;
      p3 = 1;
      for (k = 0; k < n; k++) begin
         wh += (32'(held[n-1-k]) % 3) * p3;
         ph += (32'(pat_at(k)) % 3) * p3;
         p3 *= 3;
      end
      wh &= 32'h03FF_FFFF;
      if (held_count < n || wh != ph) return;
      first = stream_pos - POS_W'(n) + 1;
      for (k = 0; k < n; k++) begin
         differs = held[n-1-k] != pat_at(k);
         item.pos = first + POS_W'(k);
         item.last = differs || (k + 1 == n);
         scan_run.push_back(item);
         if (differs) break;
      end
   endfunction

   task automatic send_text(input logic [BYTE_W-1:0] b, input logic ls, input logic typed,
                            input logic hit, input logic [POS_W-1:0] pos, input logic last);
      int                gap;
      compared_byte_type item;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = gaps_on ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_text_byte  <= b;
      req_line_start <= ls;
      do @(posedge clock); while (req_stall);
      predict_scan(b, ls);
      if (typed) begin
         if (hit) begin
            item.pos = pos;
            item.last = last;
            expected_runs.push_back(item);
         end
      end else begin
         foreach (scan_run[i]) expected_runs.push_back(scan_run[i]);
      end
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic ls);
      send_text(b, ls, 1'b0, 1'b0, '0, 1'b0);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_runs.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_PATTERN_LENGTH: len_reg = value[LEN_W-1:0];
         REG_PATTERN_LOW:    pat_lo_reg = value;
         default:            pat_hi_reg = value;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_search_phase(input int phase);
      int unsigned       n, j, k, kind, sent;
      logic [LEN_W-1:0]  len_val;
      logic [BYTE_W-1:0] b;
      logic              ls_first;
      logic              ls;
      case (phase)
         0:       len_val = 5'd16;
         1:       len_val = 5'd0;
         2:       len_val = LEN_W'($urandom_range(17, 31));
         3:       len_val = LEN_W'($urandom_range(7, 15));
         default: len_val = LEN_W'($urandom_range(1, 6));
      endcase
      drain_results();
      write_register(REG_PATTERN_LENGTH, CSR_DATA_W'(len_val));
      if (phase < 3 || $urandom_range(0, 2) != 0)
         write_register(REG_PATTERN_LOW, {$urandom, $urandom});
      if (phase < 3 || $urandom_range(0, 2) == 0)
         write_register(REG_PATTERN_HIGH, {$urandom, $urandom});
      gaps_on = ($urandom_range(0, 3) != 0);
      n = active_len();
      sent = 0;
      while (sent < PHASE_ITEMS && items_sent < TARGET_ITEMS) begin
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            // pattern occurrence, clean, with one byte broken, or split by a line start
            j = $urandom_range(0, n - 1);
            ls_first = ($urandom_range(0, 2) == 0);
            for (k = 0; k < n; k++) begin
               b = pat_at(k);
               ls = (k == 0) && ls_first;
               if ((kind == 4 || kind == 5) && k == j)
                  b = (b > 8'd252) ? b - 8'd3 : b + 8'd3;
               if (kind == 6 && k == j)
                  ls = 1'b1;
               send_byte(b, ls);
               sent++;
            end
         end else begin
            send_byte(BYTE_W'($urandom), $urandom_range(0, 9) == 0);
            sent++;
         end
      end
   endtask

   always @(posedge clock) begin
      compared_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_runs.size() == 0) begin
            $error("unexpected transfer: position %0d last_of_run %0b",
                   rsp_position, rsp_last_of_run);
            fail_count++;
         end else begin
            want = expected_runs.pop_front();
            if (rsp_position !== want.pos) begin
               $error("position: expected %0d, got %0d", want.pos, rsp_position);
               fail_count++;
            end
            if (rsp_last_of_run !== want.last) begin
               $error("last_of_run: expected %0b, got %0b", want.last, rsp_last_of_run);
               fail_count++;
            end
         end
      end
   end

   // result side: stall patterns, plus one long hold on request
   initial begin
      stall_mode_type mode;
      int             mode_left, tick, hold_left;
      mode = STALL_NONE;
      mode_left = 0;
      tick = 0;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            tick++;
            case (mode)
               STALL_NONE:   rsp_stall <= 1'b0;
               STALL_RANDOM: rsp_stall <= ($urandom_range(0, 99) < 40);
               STALL_SQUARE: rsp_stall <= (tick % 6) < 3;
               default:      rsp_stall <= (tick % 9) == 0;
            endcase
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("rolling_hash_substring_matcher_core regression: fail");
      $finish;
   end

   initial begin
      int phase;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_text_byte  = '0;
      req_line_start = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      len_reg        = 5'd1;
      pat_lo_reg     = '0;
      pat_hi_reg     = '0;
      held_count     = '0;
      stream_pos     = '0;
      foreach (held[i]) held[i] = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < $size(SCRIPT); r++) begin
         if (SCRIPT[r].kind == ROW_CSR) begin
            drain_results();
            write_register(SCRIPT[r].reg_idx, SCRIPT[r].value);
         end else begin
            send_text(SCRIPT[r].text, SCRIPT[r].line_start, SCRIPT[r].typed,
                      SCRIPT[r].hit, SCRIPT[r].pos, SCRIPT[r].last);
         end
      end

      // back-to-back hits while the result side holds off
      drain_results();
      write_register(REG_PATTERN_LENGTH, 64'd2);
      write_register(REG_PATTERN_LOW, {$urandom, $urandom});
      gaps_on = 1'b0;
      hold_request = 1'b1;
      repeat (30) begin
         send_byte(pat_at(0), 1'b0);
         send_byte(pat_at(1), 1'b0);
      end

      phase = 0;
      while (items_sent < TARGET_ITEMS) begin
         run_search_phase(phase);
         phase++;
      end

      drain_results();
      if (fail_count == 0 && expected_runs.size() == 0)
         $display("rolling_hash_substring_matcher_core regression: pass");
      else
         $display("rolling_hash_substring_matcher_core regression: fail");
      $finish;
   end

endmodule
